FILE: sv/ilb_pkg.sv
// shared types and constants for the indexed list buffer
package ilb_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int ECNT_W = 7;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // locate tree: groups of eight cells
  localparam int GRP    = 8;
  localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
  localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int BSEL_W = $clog2(GRP);

  localparam logic [2:0] OP_APPEND     = 3'd0;
  localparam logic [2:0] OP_INSERT     = 3'd1;
  localparam logic [2:0] OP_REMOVE_AT  = 3'd2;
  localparam logic [2:0] OP_REMOVE_VAL = 3'd3;
  localparam logic [2:0] OP_DROP       = 3'd4;
  localparam logic [2:0] OP_READ       = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]              operation;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] item_value;
  } ilb_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DATA_W-1:0] read_value;
    logic [ECNT_W-1:0]       entry_count;
  } ilb_out_t;

  typedef enum logic [1:0] {
    K_HOLD   = 2'd0,
    K_INSERT = 2'd1,
    K_REMOVE = 2'd2
  } shift_kind_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    shift_kind_t       kind;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

FILE: sv/ilb_cell.sv
// one list entry: shifts with its neighbours and flags key and index matches
module ilb_cell (
  input  logic                       clk,
  input  ilb_pkg::cell_cmd_t         cmd,
  input  logic [ilb_pkg::CMP_W-1:0]  cell_idx,
  input  logic [ilb_pkg::DATA_W-1:0] lower_entry,
  input  logic [ilb_pkg::DATA_W-1:0] upper_entry,
  output logic [ilb_pkg::DATA_W-1:0] entry,
  output logic                       match,
  output logic                       hit
);
  import ilb_pkg::*;

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.kind)
      K_INSERT: begin
        if (cell_idx == cmd.pos) begin
          entry_nxt = cmd.value;
        end else if (cell_idx > cmd.pos) begin
          entry_nxt = lower_entry;
        end
      end
      K_REMOVE: begin
        if (cell_idx >= cmd.pos) begin
          entry_nxt = upper_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  // only live entries take part in the value search
  assign match = (entry_r == cmd.value) && (cell_idx < cmd.count);
  assign hit   = (cell_idx == cmd.pos);

endmodule

FILE: sv/ilb_locate.sv
// two-level tree: first matching cell and the word at the read index
module ilb_locate (
  input  logic                       clk,
  input  logic [ilb_pkg::DATA_W-1:0] entries [ilb_pkg::DEPTH],
  input  logic [ilb_pkg::DEPTH-1:0]  match_vec,
  input  logic [ilb_pkg::DEPTH-1:0]  hit_vec,
  output logic                       found,
  output logic [ilb_pkg::IDX_W-1:0]  found_idx,
  output logic [ilb_pkg::DATA_W-1:0] read_word
);
  import ilb_pkg::*;

  logic [GRP-1:0]    grp_match_r [NGRP];
  logic [DATA_W-1:0] grp_word_r  [NGRP];
  logic [GRP-1:0]    grp_match_nxt [NGRP];
  logic [DATA_W-1:0] grp_word_nxt  [NGRP];

  // first level: per group match bits and or of the selected word
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_match_nxt[g] = '0;
      grp_word_nxt[g]  = '0;
      for (int b = 0; b < GRP; b++) begin
        if (g * GRP + b < DEPTH) begin
          grp_match_nxt[g][b] = match_vec[g * GRP + b];
          if (hit_vec[g * GRP + b]) begin
            grp_word_nxt[g] = grp_word_nxt[g] | entries[g * GRP + b];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_match_r[g] <= grp_match_nxt[g];
      grp_word_r[g]  <= grp_word_nxt[g];
    end
  end

  logic [GSEL_W-1:0] gsel;
  logic [BSEL_W-1:0] bsel;
  logic [GRP-1:0]    sel_bits;

  // second level: lowest group with a match, then lowest bit inside it
  always_comb begin
    gsel      = '0;
    found     = 1'b0;
    read_word = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (|grp_match_r[g]) begin
        gsel  = GSEL_W'(g);
        found = 1'b1;
      end
      read_word = read_word | grp_word_r[g];
    end
    sel_bits = grp_match_r[gsel];
    bsel     = '0;
    for (int b = GRP - 1; b >= 0; b--) begin
      if (sel_bits[b]) begin
        bsel = BSEL_W'(b);
      end
    end
    found_idx = IDX_W'({gsel, bsel});
  end

endmodule

FILE: sv/indexed_list_buffer.sv
// indexed list buffer: ordered list held in a row of shifting cells
// append, insert, remove at index, drop: result strobed in the cycle after start
// read, remove by value: pass states scan then pick (two-level locate tree); a found value adds a shift state
// throughput: one word per cycle for shift-only operations, busy blocks start otherwise
// reset: synchronous active-low, clears count and control; cell contents are not cleared
// results are strobed for one cycle; the receiver cannot stall
module indexed_list_buffer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ilb_pkg::ilb_in_t  in_word,
  output logic             out_strobe,
  output ilb_pkg::ilb_out_t out_word
);
  import ilb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_PICK  = 4'b0100,
    S_SHIFT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [CMP_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              strobe_r, strobe_nxt;
  ilb_out_t          res_r, res_nxt;

  cell_cmd_t         cmd;
  logic [DATA_W-1:0] entries [DEPTH];
  logic [DEPTH-1:0]  match_vec;
  logic [DEPTH-1:0]  hit_vec;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [DATA_W-1:0] read_word;

  logic [CMP_W-1:0]  in_pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              full;

  assign in_pos_ext = CMP_W'(in_word.position);
  assign cnt_ext    = CMP_W'(count_r);
  assign full       = (count_r == CNT_W'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ilb_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .cell_idx    (CMP_W'(i)),
      .lower_entry (entries[(i == 0) ? 0 : i - 1]),
      .upper_entry (entries[(i == DEPTH - 1) ? i : i + 1]),
      .entry       (entries[i]),
      .match       (match_vec[i]),
      .hit         (hit_vec[i])
    );
  end

  ilb_locate u_locate (
    .clk       (clk),
    .entries   (entries),
    .match_vec (match_vec),
    .hit_vec   (hit_vec),
    .found     (found),
    .found_idx (found_idx),
    .read_word (read_word)
  );

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    count_nxt  = count_r;
    strobe_nxt = 1'b0;
    res_nxt    = '0;
    cmd.kind   = K_HOLD;
    cmd.pos    = pos_r;
    cmd.count  = cnt_ext;
    cmd.value  = val_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_word.operation;
          pos_nxt    = in_pos_ext;
          val_nxt    = in_word.item_value;
          strobe_nxt = 1'b1;
          res_nxt.status = ST_OK;
          cmd.value  = in_word.item_value;
          case (in_word.operation)
            OP_APPEND: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                cmd.kind  = K_INSERT;
                cmd.pos   = cnt_ext;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_INSERT: begin
              if (in_pos_ext > cnt_ext) begin
                res_nxt.status = ST_RANGE;
              end else if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                cmd.kind  = K_INSERT;
                cmd.pos   = in_pos_ext;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_REMOVE_AT: begin
              if (in_pos_ext >= cnt_ext) begin
                res_nxt.status = ST_RANGE;
              end else begin
                cmd.kind  = K_REMOVE;
                cmd.pos   = in_pos_ext;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_REMOVE_VAL, OP_READ: begin
              strobe_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
            OP_DROP: begin
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
            end
            default: begin
              res_nxt.status = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        state_nxt = S_IDLE;
        if (op_r == OP_READ) begin
          strobe_nxt = 1'b1;
          if (pos_r >= cnt_ext) begin
            res_nxt.status = ST_RANGE;
          end else begin
            res_nxt.read_value = read_word;
          end
        end else if (found) begin
          pos_nxt   = CMP_W'(found_idx);
          state_nxt = S_SHIFT;
        end else begin
          strobe_nxt     = 1'b1;
          res_nxt.status = ST_NOTFOUND;
        end
      end
      S_SHIFT: begin
        cmd.kind   = K_REMOVE;
        count_nxt  = count_r - 1'b1;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    res_nxt.entry_count = ECNT_W'(CMP_W'(count_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    res_r <= res_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_word   = res_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_shift_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> $past(state_r) == S_PICK)
    else $error("remove shift not preceded by locate");

  a_read_no_early_word: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.operation == OP_READ |=> !out_strobe)
    else $error("read word strobed before locate finished");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.status == ST_FULL |-> out_word.entry_count == ECNT_W'(DEPTH))
    else $error("full status with count below depth");
`endif

endmodule
